// ===== hdl/shortest_job_first_dispatcher_defines.svh =====
// Assertion macros for the shortest-job-first dispatcher.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef SHORTEST_JOB_FIRST_DISPATCHER_DEFINES_SVH
`define SHORTEST_JOB_FIRST_DISPATCHER_DEFINES_SVH

// same-cycle implication
`define SJFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SJFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sjfd_pkg.sv =====
// Shared types and codes for the shortest-job-first dispatcher.
// No dependencies; used by sjfd_cell and shortest_job_first_dispatcher.
package sjfd_pkg;

  localparam int EST_W       = 24;
  localparam int ID_W        = 6;
  localparam int ST_W        = 2;
  localparam int CODE_W      = 3;
  localparam int CMD_W       = 2;
  localparam int LIMIT_W     = 7;
  localparam int NRES_W      = 7;
  localparam int MAX_RESULTS = 64;

  // commands
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS   = 2'd3;

  // result codes
  localparam logic [CODE_W-1:0] RES_ADDED       = 3'd0;
  localparam logic [CODE_W-1:0] RES_FULL        = 3'd1;
  localparam logic [CODE_W-1:0] RES_STARTED     = 3'd2;
  localparam logic [CODE_W-1:0] RES_NONE        = 3'd3;
  localparam logic [CODE_W-1:0] RES_COMPLETED   = 3'd4;
  localparam logic [CODE_W-1:0] RES_NOT_RUNNING = 3'd5;
  localparam logic [CODE_W-1:0] RES_STATUS      = 3'd6;
  localparam logic [CODE_W-1:0] RES_EMPTY       = 3'd7;

  // task states
  localparam logic [ST_W-1:0] TS_WAITING = 2'd0;
  localparam logic [ST_W-1:0] TS_RUNNING = 2'd1;
  localparam logic [ST_W-1:0] TS_DONE    = 2'd2;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_ROTATE = 2'd2;

  typedef struct packed {
    logic [EST_W-1:0] est;
    logic [ID_W-1:0]  id;
    logic [ST_W-1:0]  st;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     new_entry;
  } cell_ctl_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ID_W-1:0]   id;
    logic [EST_W-1:0]  est;
    logic [ST_W-1:0]   st;
  } result_t;

endpackage

// ===== hdl/sjfd_cell.sv =====
// One slot of the sorted task chain: holds an entry, inserts or shifts on
// broadcast control, rotates toward the head during scans. Uses sjfd_pkg.
module sjfd_cell (
  input  logic              clk,
  input  sjfd_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              left_greater,
  input  sjfd_pkg::entry_t  left_entry,
  input  sjfd_pkg::entry_t  right_entry,
  output logic              greater,
  output sjfd_pkg::entry_t  entry
);
  import sjfd_pkg::*;

  entry_t entry_next;

  // an empty slot sorts after everything
  assign greater = !occupied || (entry.est > ctl.new_entry.est);

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CELL_INSERT: begin
        if (left_greater) begin
          entry_next = left_entry;
        end else if (greater) begin
          entry_next = ctl.new_entry;
        end
      end
      CELL_ROTATE: entry_next = right_entry;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/shortest_job_first_dispatcher.sv =====
// Shortest-job-first dispatcher: a row of sjfd_cell slots kept sorted by
// estimated time, plus the command sequencer. Uses sjfd_pkg and the defines.
//
// Usage:
//   Requests enter on s_tvalid/s_tready; s_tuser is the command (0 add,
//   1 complete, 2 dispatch, 3 status), s_tdata carries est_time and task_id.
//   Results leave on m_tvalid/m_tready; m_tuser is the result code, m_tlast
//   marks the final result of a request. cfg_valid/cfg_data writes the
//   parallel limit (always ready); write it only while the block is idle.
//   Add inserts in parallel across the chain and its result is registered
//   on acceptance. Complete, dispatch and status rotate the whole chain
//   through the head slot, one slot per cycle while the output is not
//   stalled, and the next request is taken only after the last result
//   is loaded; adds go one per cycle while the output is not stalled.
//   Results are held one step in a pending register so the last flag is
//   known before a result is sent.
//   Reset empties the table, zeroes the running count and sets the limit
//   to 1; slot contents are not cleared and no clearing pass is needed.
//   A stalled receiver freezes the scan: the chain rotates only when the
//   output register is free or being drained.
module shortest_job_first_dispatcher #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // est_time[23:0], task_id[29:24], zero pad
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_task_id[5:0], out_est_time[29:6], task_state[31:30]
  output logic [2:0]  m_tuser,   // code
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import sjfd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state, state_next;
  logic [CNT_W-1:0]   entry_count;
  logic [LIMIT_W-1:0] running_count, running_next;
  logic [LIMIT_W-1:0] parallel_limit;
  logic [IDX_W-1:0]   scan_idx;
  logic [NRES_W-1:0]  res_count;
  logic [CMD_W-1:0]   cmd_q;
  logic [ID_W-1:0]    id_q;
  logic               found;
  logic               pend_valid;
  result_t            pend;
  result_t            out_q;
  result_t            load_res;
  logic               load_last;
  logic               load;

  entry_t             cells [TABLE_DEPTH];
  logic               greater [TABLE_DEPTH];
  cell_ctl_t          ctl;
  entry_t             head_next;
  logic               cand_valid;
  result_t            cand;
  logic               head_occ;
  logic               full;
  logic               can_load;
  logic               accept;
  logic [EST_W-1:0]   in_est;
  logic [ID_W-1:0]    in_id;

  assign in_est    = s_tdata[EST_W-1:0];
  assign in_id     = s_tdata[EST_W+ID_W-1:EST_W];
  assign full      = (entry_count == CNT_W'(TABLE_DEPTH));
  assign can_load  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && can_load;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign head_occ  = (CNT_W'(scan_idx) < entry_count);

  // chain of slots
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   lg;
    entry_t le;
    entry_t re;
    assign occ = (CNT_W'(i) < entry_count);
    if (i == 0) begin : g_first
      assign lg = 1'b0;
      assign le = ctl.new_entry;
    end else begin : g_mid
      assign lg = greater[i-1];
      assign le = cells[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign re = head_next;
    end else begin : g_inner
      assign re = cells[i+1];
    end
    sjfd_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occupied     (occ),
      .left_greater (lg),
      .left_entry   (le),
      .right_entry  (re),
      .greater      (greater[i]),
      .entry        (cells[i])
    );
  end

  // head slot processing during a scan
  always_comb begin
    head_next    = cells[0];
    cand_valid   = 1'b0;
    cand         = '0;
    running_next = running_count;
    case (cmd_q)
      CMD_DISPATCH: begin
        if (head_occ && cells[0].st == TS_WAITING && running_count < parallel_limit &&
            res_count < NRES_W'(MAX_RESULTS)) begin
          head_next.st = TS_RUNNING;
          running_next = running_count + LIMIT_W'(1);
          cand_valid   = 1'b1;
          cand         = '{code: RES_STARTED, id: cells[0].id, est: cells[0].est,
                           st: TS_RUNNING};
        end
      end
      CMD_STATUS: begin
        if (head_occ && res_count < NRES_W'(MAX_RESULTS)) begin
          cand_valid = 1'b1;
          cand       = '{code: RES_STATUS, id: cells[0].id, est: cells[0].est,
                         st: cells[0].st};
        end
      end
      CMD_COMPLETE: begin
        if (head_occ && !found && cells[0].id == id_q) begin
          cand_valid = 1'b1;
          if (cells[0].st == TS_RUNNING) begin
            head_next.st = TS_DONE;
            running_next = (running_count != '0) ? running_count - LIMIT_W'(1) : '0;
            cand = '{code: RES_COMPLETED, id: id_q, est: cells[0].est, st: TS_DONE};
          end else begin
            cand = '{code: RES_NOT_RUNNING, id: id_q, est: cells[0].est,
                     st: cells[0].st};
          end
        end
      end
      default: begin
        cand_valid = 1'b0;
      end
    endcase
  end

  // cell control and output load selection
  always_comb begin
    ctl                 = '0;
    ctl.op              = CELL_HOLD;
    ctl.new_entry.est   = in_est;
    ctl.new_entry.id    = ID_W'(entry_count);
    ctl.new_entry.st    = TS_WAITING;
    load                = 1'b0;
    load_last           = 1'b0;
    load_res            = pend;
    state_next          = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == CMD_ADD) begin
            load      = 1'b1;
            load_last = 1'b1;
            if (full) begin
              load_res = '{code: RES_FULL, id: '0, est: in_est, st: TS_WAITING};
            end else begin
              ctl.op   = CELL_INSERT;
              load_res = '{code: RES_ADDED, id: ID_W'(entry_count), est: in_est,
                           st: TS_WAITING};
            end
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (can_load) begin
          ctl.op = CELL_ROTATE;
          // previous result goes out once a newer one shows it is not the last
          if (cand_valid && pend_valid) begin
            load = 1'b1;
          end
          if (scan_idx == IDX_W'(TABLE_DEPTH - 1)) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (can_load) begin
          load       = 1'b1;
          load_last  = 1'b1;
          state_next = ST_IDLE;
          if (!pend_valid) begin
            case (cmd_q)
              CMD_DISPATCH: load_res = '{code: RES_NONE, id: '0, est: '0, st: '0};
              CMD_STATUS:   load_res = '{code: RES_EMPTY, id: '0, est: '0, st: '0};
              default:      load_res = '{code: RES_NOT_RUNNING, id: id_q, est: '0,
                                          st: '0};
            endcase
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_count    <= '0;
      running_count  <= '0;
      parallel_limit <= LIMIT_W'(1);
      m_tvalid       <= 1'b0;
      pend_valid     <= 1'b0;
      found          <= 1'b0;
      scan_idx       <= '0;
      res_count      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        parallel_limit <= cfg_data;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctl.op == CELL_INSERT) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (state == ST_IDLE && accept) begin
        scan_idx   <= '0;
        res_count  <= '0;
        pend_valid <= 1'b0;
        found      <= 1'b0;
      end else if (state == ST_SCAN && can_load) begin
        scan_idx      <= scan_idx + IDX_W'(1);
        running_count <= running_next;
        if (cand_valid) begin
          pend_valid <= 1'b1;
          res_count  <= res_count + NRES_W'(1);
          found      <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      cmd_q <= s_tuser;
      id_q  <= in_id;
    end
    if (state == ST_SCAN && can_load && cand_valid) begin
      pend <= cand;
    end
    if (load) begin
      out_q   <= load_res;
      m_tlast <= load_last;
    end
  end

  assign m_tdata = {out_q.st, out_q.est, out_q.id};
  assign m_tuser = out_q.code;

  `include "shortest_job_first_dispatcher_defines.svh"

  `SJFD_ASSERT_NOW(a_running_le_entries, 1'b1, CNT_W'(running_count) <= entry_count, "running count exceeds table fill")
  `SJFD_ASSERT_NEXT(a_add_grows, accept && s_tuser == CMD_ADD && !full, entry_count == $past(entry_count) + CNT_W'(1), "add did not grow the table")
  `SJFD_ASSERT_NEXT(a_stall_freezes_scan, m_tvalid && !m_tready, $stable(scan_idx), "scan advanced while output stalled")

endmodule
